### hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// Fenwick prefix sum table package
// Shared widths, command codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int CMD_W            = 2;
    localparam int SIZE_W           = 11;
    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FOLD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [SIZE_W-1:0] found_count;
        logic              error;
    } t_result;

endpackage

### hdl/fps_cmd_if.sv
// ----------------------------------------------------------------------------
// Fenwick prefix sum table command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
interface fps_cmd_if import fps_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SIZE_W-1:0] position;
    logic [DATA_W-1:0] amount;
    logic [DATA_W-1:0] threshold;

    modport source (output valid, output command, output position, output amount,
                    output threshold, input ready);
    modport sink   (input valid, input command, input position, input amount,
                    input threshold, output ready);

endinterface

### hdl/fps_res_if.sv
// ----------------------------------------------------------------------------
// Fenwick prefix sum table result channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface fps_res_if import fps_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sum;
    logic [SIZE_W-1:0] found_count;
    logic              error;

    modport source (output valid, output sum, output found_count, output error,
                    input ready);
    modport sink   (input valid, input sum, input found_count, input error,
                    output ready);

endinterface

### hdl/fps_ram.sv
// ----------------------------------------------------------------------------
// Fenwick prefix sum table RAM
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fps_ram import fps_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = MAX_ELEMENTS_DEF + 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/fps_ctrl.sv
// ----------------------------------------------------------------------------
// Fenwick prefix sum table sequencer
// Walks the tree nodes of one command through the RAM and holds the result beat.
// ----------------------------------------------------------------------------
module fps_ctrl import fps_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    localparam int AW = $clog2(MAX_ELEMENTS + 1),
    localparam int LW = (AW > SIZE_W) ? AW : SIZE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LW-1:0]     i_size,
    input  logic              i_clear,
    fps_cmd_if.sink           i_cmd,
    fps_res_if.source         o_res,
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output logic [DATA_W-1:0] o_ram_wdata,
    output logic [AW-1:0]     o_ram_raddr,
    input  logic [DATA_W-1:0] i_ram_rdata
);

    localparam int XW = LW + 1;

    function automatic logic [LW-1:0] f_top_bit(input logic [LW-1:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int b = 0; b < LW; b++) begin
            if (v[b]) begin
                r = LW'(1) << b;
            end
        end
        return r;
    endfunction

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [XW-1:0]     r_idx, n_idx;
    logic [XW-1:0]     r_i, n_i;
    logic [XW-1:0]     r_k, n_k;
    logic [DATA_W-1:0] r_amt, r_thr;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [AW-1:0]     r_clr_addr;
    t_result           r_res, n_res;
    t_result           r_out;
    logic              r_out_valid;

    logic              w_accept, w_imm, w_last, w_out_free, w_take;
    logic [XW-1:0]     w_size, w_pos, w_top;
    logic [XW-1:0]     w_add_next, w_fold_next, w_s_i, w_s_k, w_s_j, w_found;
    logic [DATA_W-1:0] w_trial, w_s_acc;
    t_result           w_imm_res;

    assign w_size     = XW'(i_size);
    assign w_pos      = XW'(i_cmd.position);
    assign w_top      = XW'(f_top_bit(i_size));
    assign w_accept   = i_cmd.valid & i_cmd.ready;
    assign w_out_free = ~r_out_valid | o_res.ready;

    assign w_add_next  = r_idx + (r_idx & (~r_idx + XW'(1)));
    assign w_fold_next = r_idx & (r_idx - XW'(1));
    assign w_trial     = r_acc + i_ram_rdata;
    assign w_take      = (r_idx <= w_size) && (w_trial < r_thr);
    assign w_s_i       = w_take ? r_idx : r_i;
    assign w_s_acc     = w_take ? w_trial : r_acc;
    assign w_s_k       = r_k >> 1;
    assign w_s_j       = w_s_i | w_s_k;
    assign w_found     = w_s_i + XW'(1);

    always_comb begin
        w_imm_res = '0;
        case (i_cmd.command)
            CMD_ADD: begin
                w_imm               = (w_pos >= w_size);
                w_imm_res.error     = w_imm;
            end
            CMD_FOLD: begin
                w_imm               = (w_pos > w_size) || (w_pos == '0);
                w_imm_res.error     = (w_pos > w_size);
            end
            CMD_SEARCH: begin
                w_imm               = (i_cmd.threshold == '0);
            end
            default: begin
                w_imm               = 1'b1;
                w_imm_res.error     = 1'b1;
            end
        endcase
    end

    always_comb begin
        case (r_cmd)
            CMD_ADD:    w_last = (w_add_next > w_size);
            CMD_FOLD:   w_last = (w_fold_next == '0);
            CMD_SEARCH: w_last = r_k[0];
            default:    w_last = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(MAX_ELEMENTS)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_imm ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_clear) begin
            n_state = S_CLEAR;
        end
    end

    always_comb begin
        n_idx       = r_idx;
        n_i         = r_i;
        n_k         = r_k;
        n_acc       = r_acc;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx[AW-1:0];
        o_ram_wdata = i_ram_rdata + r_amt;
        o_ram_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                o_ram_wdata = '0;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_acc = '0;
                    n_i   = '0;
                    n_res = w_imm_res;
                    case (i_cmd.command)
                        CMD_ADD:    n_idx = w_pos + XW'(1);
                        CMD_FOLD:   n_idx = w_pos;
                        CMD_SEARCH: begin
                            n_idx = w_top;
                            n_k   = w_top;
                        end
                        default:    n_idx = r_idx;
                    endcase
                    if (!w_imm) begin
                        o_ram_raddr = n_idx[AW-1:0];
                    end
                end
            end
            S_RUN: begin
                case (r_cmd)
                    CMD_ADD: begin
                        o_ram_we = 1'b1;
                        n_idx    = w_add_next;
                        n_res    = '0;
                        if (!w_last) begin
                            o_ram_raddr = w_add_next[AW-1:0];
                        end
                    end
                    CMD_FOLD: begin
                        n_acc       = w_trial;
                        n_idx       = w_fold_next;
                        o_ram_raddr = w_fold_next[AW-1:0];
                        n_res       = '0;
                        n_res.sum   = w_trial;
                    end
                    CMD_SEARCH: begin
                        n_i   = w_s_i;
                        n_acc = w_s_acc;
                        n_k   = w_s_k;
                        n_idx = w_s_j;
                        if (w_s_j <= w_size) begin
                            o_ram_raddr = w_s_j[AW-1:0];
                        end
                        n_res             = '0;
                        n_res.found_count = w_found[SIZE_W-1:0];
                    end
                    default: begin
                        n_res = r_res;
                    end
                endcase
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_clr_addr <= '0;
            end else if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.command;
            r_amt <= i_cmd.amount;
            r_thr <= i_cmd.threshold;
        end
        r_idx <= n_idx;
        r_i   <= n_i;
        r_k   <= n_k;
        r_acc <= n_acc;
        r_res <= n_res;
        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.sum         = r_out.sum;
    assign o_res.found_count = r_out.found_count;
    assign o_res.error       = r_out.error;

    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == S_CLEAR || (r_state == S_RUN && r_cmd == CMD_ADD)))
        else $error("RAM written outside a clearing sweep or an add walk");

    a_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cmd != CMD_SEARCH) |-> (r_idx != '0 && r_idx <= w_size))
        else $error("Tree walk left the active node range");

    a_search_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cmd == CMD_SEARCH) |-> $onehot(r_k))
        else $error("Search step bit is not a single bit");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("Command beat accepted without leaving idle");

endmodule

### hdl/fenwick_prefix_sum_table_top.sv
// ----------------------------------------------------------------------------
// Fenwick prefix sum table
// Binary indexed tree of 32-bit sums with add, prefix sum and search commands.
// ----------------------------------------------------------------------------
// After reset and after every write of the size register the block sweeps the
// whole node memory to zero and takes no command beat meanwhile. A command
// visits up to floor(log2(size))+1 tree nodes for add and prefix sum, exactly
// floor(log2(size))+1 for search, and none for a rejected command or a zero
// threshold. The node memory gives one read and one write per cycle, and the
// write back of one node overlaps the read of the next. Results leave through
// an output register, so the next command is taken while the last result
// beat still waits.
module fenwick_prefix_sum_table_top import fps_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    fps_cmd_if.sink           i_cmd,
    fps_res_if.source         o_res
);

    localparam int AW = $clog2(MAX_ELEMENTS + 1);
    localparam int LW = (AW > SIZE_W) ? AW : SIZE_W;

    logic [LW-1:0]     r_size, n_size;
    logic [LW-1:0]     w_cfg;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr, w_ram_raddr;
    logic [DATA_W-1:0] w_ram_wdata, w_ram_rdata;

    assign w_cfg = LW'(i_cfg_data);

    always_comb begin
        if (w_cfg == '0) begin
            n_size = LW'(1);
        end else if (w_cfg > LW'(MAX_ELEMENTS)) begin
            n_size = LW'(MAX_ELEMENTS);
        end else begin
            n_size = w_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= LW'(MAX_ELEMENTS);
        end else if (i_cfg_we) begin
            r_size <= n_size;
        end
    end

    fps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS + 1)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    fps_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (r_size),
        .i_clear     (i_cfg_we),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fenwick prefix sum table testbench
// Drives add, prefix sum and search commands over several table sizes and
// checks every result beat against a local binary indexed tree that tracks
// each accepted command, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    import fps_pkg::*;

    localparam int                 TABLE_DEPTH   = MAX_ELEMENTS_DEF;
    localparam int                 CLEAR_CYCLES  = TABLE_DEPTH + 1;
    localparam int                 SETTLE_CYCLES = 16;
    localparam int                 CYCLE_LIMIT   = 400000;
    localparam int                 PRINT_LIMIT   = 100;
    localparam logic [CMD_W-1:0]   CMD_ILLEGAL   = 2'd3;
    localparam logic [DATA_W-1:0]  ALL_ONES      = 32'hFFFF_FFFF;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    fps_cmd_if cmd_if ();
    fps_res_if res_if ();

    fenwick_prefix_sum_table_top #(
        .MAX_ELEMENTS (TABLE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    logic [DATA_W-1:0] tree_nodes [0:TABLE_DEPTH];
    int unsigned       table_size;
    t_result           pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned beat_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_off_left  = 0;
    bit          tx_gaps_on     = 1'b1;
    bit          rx_stalls_on   = 1'b1;

    always #4 i_clk = ~i_clk;

    function automatic logic [DATA_W-1:0] tree_prefix(input int unsigned len);
        logic [DATA_W-1:0] acc;
        int unsigned       idx;
        acc = '0;
        idx = len;
        while (idx != 0) begin
            acc = acc + tree_nodes[idx];
            idx = idx & (idx - 1);
        end
        return acc;
    endfunction

    function automatic t_result tree_response(input logic [CMD_W-1:0] op,
                                              input logic [SIZE_W-1:0] pos,
                                              input logic [DATA_W-1:0] amt,
                                              input logic [DATA_W-1:0] thr);
        t_result           res;
        int unsigned       idx;
        int unsigned       base;
        int unsigned       step;
        int unsigned       probe;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] trial;
        res = '0;
        case (op)
            CMD_ADD: begin
                if (pos >= table_size) begin
                    res.error = 1'b1;
                end else begin
                    idx = pos + 1;
                    while (idx <= table_size) begin
                        tree_nodes[idx] = tree_nodes[idx] + amt;
                        idx = idx + (idx & (~idx + 1));
                    end
                end
            end
            CMD_FOLD: begin
                if (pos > table_size) begin
                    res.error = 1'b1;
                end else begin
                    res.sum = tree_prefix(pos);
                end
            end
            CMD_SEARCH: begin
                if (thr != '0) begin
                    base = 0;
                    acc  = '0;
                    step = 1;
                    while ((step << 1) <= table_size) begin
                        step = step << 1;
                    end
                    while (step != 0) begin
                        probe = base | step;
                        if (probe <= table_size) begin
                            trial = acc + tree_nodes[probe];
                            if (trial < thr) begin
                                acc  = trial;
                                base = probe;
                            end
                        end
                        step = step >> 1;
                    end
                    res.found_count = SIZE_W'(base + 1);
                end
            end
            default: begin
                res.error = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] beat %0d: %s got %0h expected %0h", $realtime, beat_count, what,
                     got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_left != 0) begin
            hold_off_left = hold_off_left - 1;
            res_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, sum", res_if.sum, 0);
            end else begin
                want = pending_results.pop_front();
                if (res_if.sum !== want.sum)
                    report_mismatch("sum", res_if.sum, want.sum);
                if (res_if.found_count !== want.found_count)
                    report_mismatch("found_count", res_if.found_count, want.found_count);
                if (res_if.error !== want.error)
                    report_mismatch("error", res_if.error, want.error);
            end
            beat_count++;
            stall_left = rx_stalls_on ? $urandom_range(0, 14) : 0;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] op, input logic [SIZE_W-1:0] pos,
                                input logic [DATA_W-1:0] amt, input logic [DATA_W-1:0] thr);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= op;
        cmd_if.position  <= pos;
        cmd_if.amount    <= amt;
        cmd_if.threshold <= thr;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_results.push_back(tree_response(op, pos, amt, thr));
    endtask

    task automatic release_command_channel();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        release_command_channel();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] value);
        wait_for_drain();
        release_command_channel();
        repeat (CLEAR_CYCLES + SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        if (value == 0) begin
            table_size = 1;
        end else if (value > TABLE_DEPTH) begin
            table_size = TABLE_DEPTH;
        end else begin
            table_size = 32'(value);
        end
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_command(input bit wide_amounts);
        int unsigned       pick;
        int unsigned       sel;
        logic [CMD_W-1:0]  op;
        logic [SIZE_W-1:0] pos;
        logic [DATA_W-1:0] amt;
        logic [DATA_W-1:0] thr;
        pick = $urandom_range(0, 99);
        pos  = SIZE_W'($urandom_range(0, 2047));
        amt  = wide_amounts ? $urandom : $urandom_range(0, 255);
        thr  = $urandom;
        if ($urandom_range(0, 9) == 0) amt = ALL_ONES - $urandom_range(0, 3);
        if (pick < 45) begin
            op = CMD_ADD;
            if ($urandom_range(0, 9) != 0) pos = SIZE_W'($urandom_range(0, table_size - 1));
        end else if (pick < 70) begin
            op = CMD_FOLD;
            if ($urandom_range(0, 9) != 0) pos = SIZE_W'($urandom_range(0, table_size));
        end else if (pick < 96) begin
            op  = CMD_SEARCH;
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                thr = tree_prefix($urandom_range(1, table_size)) + $urandom_range(0, 2) - 1;
            end else if (sel == 6) begin
                thr = '0;
            end else if (sel == 7) begin
                thr = ALL_ONES;
            end
        end else begin
            op = CMD_ILLEGAL;
        end
        send_command(op, pos, amt, thr);
    endtask

    task automatic run_random_phase(input logic [SIZE_W-1:0] size_value, input int n_items,
                                    input bit wide_amounts);
        write_table_size(size_value);
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n_items; i++) begin
            send_random_command(wide_amounts);
        end
    endtask

    task automatic test_reset_size_edges();
        send_command(CMD_ADD, 0, ALL_ONES, 0);
        send_command(CMD_ADD, 1023, 1, 0);
        send_command(CMD_ADD, 1024, 5, 0);
        send_command(CMD_ADD, 2047, 7, ALL_ONES);
        send_command(CMD_FOLD, 0, 0, 0);
        send_command(CMD_FOLD, 1024, 0, 0);
        send_command(CMD_FOLD, 1025, 0, 0);
        send_command(CMD_SEARCH, 0, 0, 0);
        send_command(CMD_SEARCH, 0, 0, ALL_ONES);
        send_command(CMD_SEARCH, 2047, ALL_ONES, 1);
        send_command(CMD_ILLEGAL, 2047, ALL_ONES, ALL_ONES);
    endtask

    task automatic test_size_limits();
        write_table_size(0);
        send_command(CMD_ADD, 0, 32'h8000_0000, 0);
        send_command(CMD_ADD, 1, 1, 0);
        send_command(CMD_FOLD, 1, 0, 0);
        send_command(CMD_FOLD, 2, 0, 0);
        send_command(CMD_SEARCH, 0, 0, 32'h8000_0001);
        write_table_size(2047);
        send_command(CMD_FOLD, 1024, 0, 0);
        write_table_size(512);
        send_command(CMD_ADD, 511, 9, 0);
        send_command(CMD_SEARCH, 0, 0, 9);
    endtask

    task automatic test_wrapped_search();
        write_table_size(8);
        send_command(CMD_ADD, 0, 32'hFFFF_FFF0, 0);
        send_command(CMD_ADD, 3, 32'h20, 0);
        send_command(CMD_SEARCH, 0, 0, 32'hFFFF_FFF8);
        send_command(CMD_SEARCH, 0, 0, 5);
        send_command(CMD_FOLD, 8, 0, 0);
    endtask

    task automatic test_random_sizes();
        run_random_phase(1024, 60, 1'b0);
        run_random_phase(37, 70, 1'b0);
        run_random_phase(64, 70, 1'b1);
        run_random_phase(2, 40, 1'b0);
        run_random_phase(1023, 90, 1'b0);
        run_random_phase(5, 40, 1'b1);
        run_random_phase(512, 90, 1'b0);
    endtask

    task automatic test_output_backpressure();
        write_table_size(16);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b1;
        @(posedge i_clk);
        hold_off_left = 300;
        for (int i = 0; i < 40; i++) begin
            send_random_command(1'b0);
        end
    endtask

    task automatic test_drained_bursts();
        write_table_size(100);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        for (int burst = 0; burst < 3; burst++) begin
            for (int i = 0; i < 10; i++) begin
                send_random_command(1'b1);
            end
            wait_for_drain();
            release_command_channel();
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.command   = '0;
        cmd_if.position  = '0;
        cmd_if.amount    = '0;
        cmd_if.threshold = '0;
        res_if.ready     = 1'b0;
        table_size       = TABLE_DEPTH;
        foreach (tree_nodes[i]) tree_nodes[i] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_size_edges();
        test_size_limits();
        test_wrapped_search();
        test_random_sizes();
        test_output_backpressure();
        test_drained_bursts();

        wait_for_drain();
        release_command_channel();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
